// ===== hdl/mhw_pkg.sv =====
// shared types, codes and reset values for the heartbeat watchdog
package mhw_pkg;

  localparam int CHANNELS_DEF = 16;
  localparam int CH_W         = 4;
  localparam int GEN_W        = 32;
  localparam int BEAT_W       = 48;
  localparam int TIME_W       = 40;
  localparam int CNT_W        = 4;
  localparam int STATUS_W     = 4;
  localparam int UNIT_W       = 48;

  // transaction kinds
  localparam logic [1:0] KIND_REGISTER   = 2'd0;
  localparam logic [1:0] KIND_UNREGISTER = 2'd1;
  localparam logic [1:0] KIND_CHECK      = 2'd2;
  localparam logic [1:0] KIND_RECOVERED  = 2'd3;

  // result status codes
  localparam logic [STATUS_W-1:0] ST_ACK         = 4'd0;
  localparam logic [STATUS_W-1:0] ST_UNMONITORED = 4'd1;
  localparam logic [STATUS_W-1:0] ST_NOT_LIVE    = 4'd2;
  localparam logic [STATUS_W-1:0] ST_REGENERATED = 4'd3;
  localparam logic [STATUS_W-1:0] ST_PROGRESS    = 4'd4;
  localparam logic [STATUS_W-1:0] ST_WAITING     = 4'd5;
  localparam logic [STATUS_W-1:0] ST_RESTART     = 4'd6;
  localparam logic [STATUS_W-1:0] ST_LIMIT       = 4'd7;
  localparam logic [STATUS_W-1:0] ST_COOLDOWN    = 4'd8;
  localparam logic [STATUS_W-1:0] ST_RECOVERED   = 4'd9;
  localparam logic [STATUS_W-1:0] ST_REC_FAILED  = 4'd10;

  // configuration register indexes
  localparam logic [1:0] REG_TIMEOUT  = 2'd0;
  localparam logic [1:0] REG_MAX_RST  = 2'd1;
  localparam logic [1:0] REG_COOLDOWN = 2'd2;

  localparam logic [31:0]      TIMEOUT_RST  = 32'd2000;
  localparam logic [CNT_W-1:0] MAX_RST_RST  = 4'd3;
  localparam logic [31:0]      COOLDOWN_RST = 32'd5000;

  typedef struct packed {
    logic [GEN_W-1:0]  gen;
    logic [BEAT_W-1:0] beat;
    logic [TIME_W-1:0] prog;
    logic [CNT_W-1:0]  rcnt;
    logic [TIME_W-1:0] lrt;
  } entry_t;

endpackage

// ===== hdl/multichannel_heartbeat_watchdog.sv =====
// heartbeat watchdog over a channel table, one shared subtractor under a sequencer
// register, unregister and recovery-done transactions pass IDLE, EVAL and DONE; checks may
// also pass STALL, TMO, LIM and COOL; a new transaction is taken the cycle after the result
// is loaded, so only one is in flight, and result channel stalls hold it in DONE; the 49-bit
// subtract/compare unit steps through the beat, stall, timeout, limit and cooldown compares
// reset (synchronous, active low) clears valid bits, counters and registers to defaults;
// the entry table itself is not cleared, there is no clearing pass
module multichannel_heartbeat_watchdog #(
  parameter int CHANNELS = mhw_pkg::CHANNELS_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [1:0]                    in_kind,
  input  logic [mhw_pkg::CH_W-1:0]      in_channel,
  input  logic [mhw_pkg::GEN_W-1:0]     in_generation,
  input  logic [mhw_pkg::BEAT_W-1:0]    in_heartbeat,
  input  logic [mhw_pkg::TIME_W-1:0]    in_now_ms,
  input  logic                          in_worker_present,
  input  logic                          in_worker_active,
  input  logic                          in_recovery_ok,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [mhw_pkg::STATUS_W-1:0]  out_status,
  output logic                          out_hang_found,
  output logic                          out_mark_failed,
  output logic                          out_restart_request,
  output logic                          out_mark_error,
  output logic [31:0]                   out_hang_total,
  output logic [4:0]                    out_monitored_count,
  output logic [mhw_pkg::CNT_W-1:0]     out_restarts_used,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [3:0]                    paddr,
  input  logic [31:0]                   pwdata,
  output logic [31:0]                   prdata,
  output logic                          pready
);

  localparam int CH_SPAN = 2 ** mhw_pkg::CH_W;
  localparam int DEPTH   = (CHANNELS < CH_SPAN) ? CHANNELS : CH_SPAN;
  localparam int IDX_W   = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam logic [8:0] CH_LIMIT = 9'(CHANNELS);

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_EVAL  = 3'd1;
  localparam logic [2:0] S_STALL = 3'd2;
  localparam logic [2:0] S_TMO   = 3'd3;
  localparam logic [2:0] S_LIM   = 3'd4;
  localparam logic [2:0] S_COOL  = 3'd5;
  localparam logic [2:0] S_DONE  = 3'd6;

  // control state
  logic [2:0]                 state_r, state_nxt;
  logic [DEPTH-1:0]           valid_r, valid_nxt;
  logic [4:0]                 cnt_r, cnt_nxt;
  logic [31:0]                hang_cnt_r, hang_cnt_nxt;
  logic [31:0]                timeout_r, cooldown_r;
  logic [mhw_pkg::CNT_W-1:0]  max_rst_r;
  logic                       out_valid_r;

  // item and working payload
  logic [1:0]                     kind_r;
  logic [mhw_pkg::CH_W-1:0]       ch_r;
  logic [mhw_pkg::GEN_W-1:0]      gen_r;
  logic [mhw_pkg::BEAT_W-1:0]     beat_r;
  logic [mhw_pkg::TIME_W-1:0]     now_r;
  logic                           present_r, active_r, rec_ok_r;
  mhw_pkg::entry_t                wk_r, wk_nxt;
  logic [mhw_pkg::UNIT_W-1:0]     sub_r, sub_nxt;
  logic [mhw_pkg::STATUS_W-1:0]   st_r, st_nxt;
  logic                           hang_r, hang_nxt;
  logic                           rst_r, rst_nxt;
  logic                           err_r, err_nxt;
  logic                           wr_r, wr_nxt;

  logic [mhw_pkg::STATUS_W-1:0]   o_status_r;
  logic                           o_hang_r, o_rst_r, o_err_r;
  logic [31:0]                    o_hang_tot_r;
  logic [4:0]                     o_cnt_r;
  logic [mhw_pkg::CNT_W-1:0]      o_used_r;

  mhw_pkg::entry_t mem [DEPTH];

  logic                       accept, out_free, finish, cfg_wr, in_range;
  logic [IDX_W-1:0]           in_idx, idx_r;
  logic [mhw_pkg::UNIT_W-1:0] unit_a, unit_b;
  logic [mhw_pkg::UNIT_W:0]   unit_diff;
  logic                       borrow;
  mhw_pkg::entry_t            enrolled;

  assign in_ready = (state_r == S_IDLE);
  assign accept   = in_valid && in_ready;
  assign out_free = !out_valid_r || out_ready;
  assign finish   = (state_r == S_DONE) && out_free;
  assign in_idx   = in_channel[IDX_W-1:0];
  assign idx_r    = ch_r[IDX_W-1:0];
  assign in_range = ({5'd0, ch_r} < CH_LIMIT);
  assign pready   = 1'b1;
  assign cfg_wr   = psel && penable && pwrite;

  assign enrolled = '{gen: gen_r, beat: '0, prog: now_r, rcnt: '0, lrt: '0};

  // shared subtract/compare unit
  always_comb begin
    unit_a = '0;
    unit_b = '0;
    unique case (state_r)
      S_EVAL: begin
        unit_a = wk_r.beat;
        unit_b = beat_r;
      end
      S_STALL: begin
        unit_a = mhw_pkg::UNIT_W'(now_r);
        unit_b = mhw_pkg::UNIT_W'(wk_r.prog);
      end
      S_TMO: begin
        unit_a = sub_r;
        unit_b = mhw_pkg::UNIT_W'(timeout_r);
      end
      S_LIM: begin
        unit_a = mhw_pkg::UNIT_W'(now_r);
        unit_b = mhw_pkg::UNIT_W'(wk_r.lrt);
      end
      S_COOL: begin
        unit_a = sub_r;
        unit_b = mhw_pkg::UNIT_W'(cooldown_r);
      end
      default: begin
        unit_a = '0;
        unit_b = '0;
      end
    endcase
  end

  assign unit_diff = {1'b0, unit_a} - {1'b0, unit_b};
  assign borrow    = unit_diff[mhw_pkg::UNIT_W];

  // sequencer
  always_comb begin
    state_nxt    = state_r;
    valid_nxt    = valid_r;
    cnt_nxt      = cnt_r;
    hang_cnt_nxt = hang_cnt_r;
    wk_nxt       = wk_r;
    sub_nxt      = sub_r;
    st_nxt       = st_r;
    hang_nxt     = hang_r;
    rst_nxt      = rst_r;
    err_nxt      = err_r;
    wr_nxt       = wr_r;
    unique case (state_r)
      S_IDLE: begin
        if (accept) begin
          state_nxt = S_EVAL;
          st_nxt    = mhw_pkg::ST_UNMONITORED;
          hang_nxt  = 1'b0;
          rst_nxt   = 1'b0;
          err_nxt   = 1'b0;
          wr_nxt    = 1'b0;
        end
      end
      S_EVAL: begin
        state_nxt = S_DONE;
        if (!in_range) begin
          st_nxt = mhw_pkg::ST_UNMONITORED;
        end else begin
          unique case (kind_r)
            mhw_pkg::KIND_REGISTER: begin
              st_nxt = mhw_pkg::ST_ACK;
              wk_nxt = enrolled;
              wr_nxt = 1'b1;
              valid_nxt[idx_r] = 1'b1;
              if (!valid_r[idx_r]) cnt_nxt = cnt_r + 5'd1;
            end
            mhw_pkg::KIND_UNREGISTER: begin
              st_nxt = mhw_pkg::ST_ACK;
              valid_nxt[idx_r] = 1'b0;
              if (valid_r[idx_r]) cnt_nxt = cnt_r - 5'd1;
            end
            mhw_pkg::KIND_RECOVERED: begin
              if (rec_ok_r) begin
                st_nxt = mhw_pkg::ST_RECOVERED;
                wk_nxt = enrolled;
                wr_nxt = 1'b1;
                valid_nxt[idx_r] = 1'b1;
                if (!valid_r[idx_r]) cnt_nxt = cnt_r + 5'd1;
              end else begin
                st_nxt  = mhw_pkg::ST_REC_FAILED;
                err_nxt = 1'b1;
              end
            end
            default: begin
              if (!valid_r[idx_r]) begin
                st_nxt = mhw_pkg::ST_UNMONITORED;
              end else if (!present_r || !active_r) begin
                st_nxt = mhw_pkg::ST_NOT_LIVE;
              end else if (gen_r != wk_r.gen) begin
                st_nxt = mhw_pkg::ST_REGENERATED;
                wk_nxt = enrolled;
                wr_nxt = 1'b1;
              end else if (borrow) begin
                // heartbeat moved past the stored one
                st_nxt      = mhw_pkg::ST_PROGRESS;
                wk_nxt.beat = beat_r;
                wk_nxt.prog = now_r;
                wr_nxt      = 1'b1;
              end else begin
                state_nxt = S_STALL;
              end
            end
          endcase
        end
      end
      S_STALL: begin
        if (borrow) begin
          // clock behind the progress time counts as within the timeout
          st_nxt    = mhw_pkg::ST_WAITING;
          state_nxt = S_DONE;
        end else begin
          sub_nxt   = unit_diff[mhw_pkg::UNIT_W-1:0];
          state_nxt = S_TMO;
        end
      end
      S_TMO: begin
        if (borrow) begin
          st_nxt    = mhw_pkg::ST_WAITING;
          state_nxt = S_DONE;
        end else begin
          hang_nxt  = 1'b1;
          if (hang_cnt_r != '1) hang_cnt_nxt = hang_cnt_r + 32'd1;
          state_nxt = S_LIM;
        end
      end
      S_LIM: begin
        state_nxt = S_DONE;
        if (wk_r.rcnt >= max_rst_r) begin
          st_nxt = mhw_pkg::ST_LIMIT;
        end else if (wk_r.lrt == '0) begin
          st_nxt      = mhw_pkg::ST_RESTART;
          rst_nxt     = 1'b1;
          wk_nxt.rcnt = wk_r.rcnt + 4'd1;
          wk_nxt.lrt  = now_r;
          wr_nxt      = 1'b1;
        end else if (borrow) begin
          st_nxt = mhw_pkg::ST_COOLDOWN;
        end else begin
          sub_nxt   = unit_diff[mhw_pkg::UNIT_W-1:0];
          state_nxt = S_COOL;
        end
      end
      S_COOL: begin
        state_nxt = S_DONE;
        if (borrow) begin
          st_nxt = mhw_pkg::ST_COOLDOWN;
        end else begin
          st_nxt      = mhw_pkg::ST_RESTART;
          rst_nxt     = 1'b1;
          wk_nxt.rcnt = wk_r.rcnt + 4'd1;
          wk_nxt.lrt  = now_r;
          wr_nxt      = 1'b1;
        end
      end
      S_DONE: begin
        if (out_free) state_nxt = S_IDLE;
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      valid_r     <= '0;
      cnt_r       <= '0;
      hang_cnt_r  <= '0;
      timeout_r   <= mhw_pkg::TIMEOUT_RST;
      max_rst_r   <= mhw_pkg::MAX_RST_RST;
      cooldown_r  <= mhw_pkg::COOLDOWN_RST;
      out_valid_r <= 1'b0;
    end else begin
      state_r    <= state_nxt;
      valid_r    <= valid_nxt;
      cnt_r      <= cnt_nxt;
      hang_cnt_r <= hang_cnt_nxt;
      if (cfg_wr) begin
        unique case (paddr[3:2])
          mhw_pkg::REG_TIMEOUT:  timeout_r  <= pwdata;
          mhw_pkg::REG_MAX_RST:  max_rst_r  <= pwdata[mhw_pkg::CNT_W-1:0];
          mhw_pkg::REG_COOLDOWN: cooldown_r <= pwdata;
          default: ;
        endcase
      end
      if (finish) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      kind_r    <= in_kind;
      ch_r      <= in_channel;
      gen_r     <= in_generation;
      beat_r    <= in_heartbeat;
      now_r     <= in_now_ms;
      present_r <= in_worker_present;
      active_r  <= in_worker_active;
      rec_ok_r  <= in_recovery_ok;
      wk_r      <= mem[in_idx];
    end else begin
      wk_r <= wk_nxt;
    end
    sub_r  <= sub_nxt;
    st_r   <= st_nxt;
    hang_r <= hang_nxt;
    rst_r  <= rst_nxt;
    err_r  <= err_nxt;
    wr_r   <= wr_nxt;
    if (finish && wr_r) mem[idx_r] <= wk_r;
    if (finish) begin
      o_status_r   <= st_r;
      o_hang_r     <= hang_r;
      o_rst_r      <= rst_r;
      o_err_r      <= err_r;
      o_hang_tot_r <= hang_cnt_r;
      o_cnt_r      <= cnt_r;
      o_used_r     <= (in_range && valid_r[idx_r]) ? wk_r.rcnt : '0;
    end
  end

  always_comb begin
    unique case (paddr[3:2])
      mhw_pkg::REG_TIMEOUT:  prdata = timeout_r;
      mhw_pkg::REG_MAX_RST:  prdata = {28'd0, max_rst_r};
      mhw_pkg::REG_COOLDOWN: prdata = cooldown_r;
      default:               prdata = '0;
    endcase
  end

  assign out_valid           = out_valid_r;
  assign out_status          = o_status_r;
  assign out_hang_found      = o_hang_r;
  assign out_mark_failed     = o_hang_r;
  assign out_restart_request = o_rst_r;
  assign out_mark_error      = o_err_r;
  assign out_hang_total      = o_hang_tot_r;
  assign out_monitored_count = o_cnt_r;
  assign out_restarts_used   = o_used_r;

  // monitored count tracks the valid bits
  a_cnt_matches: assert property (@(posedge clk) disable iff (!rst_n)
    32'(cnt_r) == $countones(valid_r))
    else $error("monitored count out of step with valid bits");

  a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> !in_ready)
    else $error("new transaction taken while one is in flight");

  a_restart_needs_hang: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && o_rst_r |-> o_hang_r && o_status_r == mhw_pkg::ST_RESTART)
    else $error("restart requested without a hang");

  a_hang_monotonic: assert property (@(posedge clk)
    rst_n && $past(rst_n) |-> hang_cnt_r >= $past(hang_cnt_r))
    else $error("hang counter went backwards");

endmodule
